// ===== rtl/sha_pkg.sv =====
package sha_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int CHAIN_WORDS = 8;
    localparam int ROUNDS      = 64;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [2:0] LAST_INDEX = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    localparam logic [31:0] INIT_H [CHAIN_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        choose = (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] major(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
        major = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// ===== rtl/sha_stream_if.sv =====
interface sha_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sha_ram.sv =====
module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/sha256_byte_stream_hasher_top.sv =====
// Channel  Role    Payload                                     Beat
// msg      sink    data_byte[7:0], byte_valid, end_of_message  one message byte and/or end mark
// digest   source  digest_word[31:0], word_index[2:0], last_word  one hash word, h0 first
//
// A message beat is taken whenever the block buffer is not busy.
// Each round of a 64-byte block uses the read states S_RD0 and S_RD1, set by
// the two read ports of the schedule memory (four schedule words per round);
// S_LAST then finishes the last round and S_FIN folds into the chain.
// An end beat is followed by the pad bytes in S_PAD, the blocks, then eight beats.
// Reset loads the initial hash values and clears the counters; no clearing pass.
// The digest channel holds its beat until it is taken; msg.ready stays low meanwhile.
module sha256_byte_stream_hasher_top (
    input  logic         clk,
    input  logic         rst_n,
    sha_stream_if.sink   msg,
    sha_stream_if.source digest
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PAD  = 7'b0000010,
        S_RD0  = 7'b0000100,
        S_RD1  = 7'b0001000,
        S_LAST = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    localparam int ADDR_W = $clog2(sha_pkg::BLOCK_WORDS);

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  round_reg, round_next;
    logic [63:0] bitcount_reg, bitcount_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        mark_sent_reg, mark_sent_next;
    logic        len_phase_reg, len_phase_next;
    logic        pad_pending_reg, pad_pending_next;
    logic [31:0] chain_reg [sha_pkg::CHAIN_WORDS];

    // Datapath registers: working variables a..h, byte assembly and round operands.
    logic [31:0]       work_reg [sha_pkg::CHAIN_WORDS];
    logic [23:0]       acc_reg;
    logic [31:0]       partial_reg;
    logic [31:0]       hk_reg;
    logic              early_reg;
    logic [ADDR_W-1:0] waddr_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [31:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr_a;
    logic [ADDR_W-1:0] ram_raddr_b;
    logic [31:0]       ram_rdata_a;
    logic [31:0]       ram_rdata_b;

    logic        accept;
    logic        push;
    logic [7:0]  push_byte;
    logic [7:0]  pad_byte;
    logic        pad_len;
    logic [63:0] len_shift;
    logic        completing;
    logic        finishing;
    logic        out_take;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;

    sha_ram #(
        .WIDTH (sha_pkg::WORD_W),
        .DEPTH (sha_pkg::BLOCK_WORDS)
    ) u_sched_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    assign msg.ready = (state_reg == S_IDLE);
    assign accept    = msg.valid && msg.ready;

    assign digest.valid               = (state_reg == S_OUT);
    assign digest.payload.digest_word = chain_reg[out_idx_reg];
    assign digest.payload.word_index  = out_idx_reg;
    assign digest.payload.last_word   = (out_idx_reg == sha_pkg::LAST_INDEX);
    assign out_take                   = digest.valid && digest.ready;

    // Padding: the mark byte, zeros up to offset 56, then the bit count MSB first.
    // The length phase is entered once the mark is out and the fill reaches 56.
    assign len_shift = bitcount_reg >> {~fill_reg[2:0], 3'b000};
    assign pad_len   = mark_sent_reg && (len_phase_reg || (fill_reg == sha_pkg::LEN_OFFSET));

    always_comb
    begin
        if (!mark_sent_reg)
        begin
            pad_byte = sha_pkg::PAD_MARK;
        end
        else if (pad_len)
        begin
            pad_byte = len_shift[7:0];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    assign push      = (accept && msg.payload.byte_valid) || (state_reg == S_PAD);
    assign push_byte = (state_reg == S_PAD) ? pad_byte : msg.payload.data_byte;

    // A round finishes in the cycle after its second read; round 0 has nothing
    // to finish, so that cycle loads the working variables instead.
    assign completing = ((state_reg == S_RD0) && (round_reg != 6'd0)) || (state_reg == S_LAST);
    assign finishing  = (state_reg == S_FIN);

    assign w_new = early_reg ? partial_reg
                             : partial_reg + ram_rdata_a + sha_pkg::small_sigma1(ram_rdata_b);
    assign t1 = hk_reg + sha_pkg::big_sigma1(work_reg[4])
              + sha_pkg::choose(work_reg[4], work_reg[5], work_reg[6]) + w_new;
    assign t2 = sha_pkg::big_sigma0(work_reg[0])
              + sha_pkg::major(work_reg[0], work_reg[1], work_reg[2]);

    // Schedule memory ports. The first read cycle fetches w[t-16] and w[t-15],
    // the second w[t-7] and w[t-2]; the new word is written where w[t-16] was.
    always_comb
    begin
        ram_raddr_a = '0;
        ram_raddr_b = '0;
        case (state_reg)
            S_RD0:
            begin
                ram_raddr_a = round_reg[ADDR_W-1:0];
                ram_raddr_b = round_reg[ADDR_W-1:0] + ADDR_W'(1);
            end
            S_RD1:
            begin
                ram_raddr_a = round_reg[ADDR_W-1:0] + ADDR_W'(9);
                ram_raddr_b = round_reg[ADDR_W-1:0] + ADDR_W'(14);
            end
            default:
            begin
                ram_raddr_a = '0;
                ram_raddr_b = '0;
            end
        endcase

        if (completing)
        begin
            ram_we    = 1'b1;
            ram_waddr = waddr_reg;
            ram_wdata = w_new;
        end
        else
        begin
            ram_we    = push && (fill_reg[1:0] == 2'b11);
            ram_waddr = fill_reg[5:2];
            ram_wdata = {acc_reg, push_byte};
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        round_next       = round_reg;
        bitcount_next    = bitcount_reg;
        out_idx_next     = out_idx_reg;
        mark_sent_next   = mark_sent_reg;
        len_phase_next   = len_phase_reg;
        pad_pending_next = pad_pending_reg;

        if (push)
        begin
            fill_next = fill_reg + 6'd1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (msg.payload.byte_valid)
                    begin
                        bitcount_next = bitcount_reg + 64'd8;
                    end
                    pad_pending_next = msg.payload.end_of_message;
                    if (msg.payload.byte_valid && (fill_reg == sha_pkg::LAST_BYTE))
                    begin
                        state_next = S_RD0;
                    end
                    else if (msg.payload.end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                mark_sent_next = 1'b1;
                if (pad_len)
                begin
                    len_phase_next = 1'b1;
                end
                if (fill_reg == sha_pkg::LAST_BYTE)
                begin
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                state_next = S_RD1;
            end
            S_RD1:
            begin
                round_next = round_reg + 6'd1;
                state_next = (round_reg == sha_pkg::LAST_ROUND) ? S_LAST : S_RD0;
            end
            S_LAST:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (len_phase_reg)
                begin
                    state_next = S_OUT;
                end
                else if (pad_pending_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (out_take)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == sha_pkg::LAST_INDEX)
                    begin
                        state_next       = S_IDLE;
                        bitcount_next    = '0;
                        mark_sent_next   = 1'b0;
                        len_phase_next   = 1'b0;
                        pad_pending_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fill_reg        <= '0;
            round_reg       <= '0;
            bitcount_reg    <= '0;
            out_idx_reg     <= '0;
            mark_sent_reg   <= 1'b0;
            len_phase_reg   <= 1'b0;
            pad_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            round_reg       <= round_next;
            bitcount_reg    <= bitcount_next;
            out_idx_reg     <= out_idx_next;
            mark_sent_reg   <= mark_sent_next;
            len_phase_reg   <= len_phase_next;
            pad_pending_reg <= pad_pending_next;
        end
    end

    // Chaining words: folded after each block, back to the initial values once
    // the last digest beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sha_pkg::CHAIN_WORDS; i++)
            begin
                chain_reg[i] <= sha_pkg::INIT_H[i];
            end
        end
        else if (finishing)
        begin
            for (int i = 0; i < sha_pkg::CHAIN_WORDS; i++)
            begin
                chain_reg[i] <= chain_reg[i] + work_reg[i];
            end
        end
        else if (out_take && (out_idx_reg == sha_pkg::LAST_INDEX))
        begin
            for (int i = 0; i < sha_pkg::CHAIN_WORDS; i++)
            begin
                chain_reg[i] <= sha_pkg::INIT_H[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            acc_reg <= {acc_reg[15:0], push_byte};
        end

        if ((state_reg == S_RD0) && (round_reg == 6'd0))
        begin
            for (int i = 0; i < sha_pkg::CHAIN_WORDS; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
        end
        else if (completing)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end

        // Second read cycle: w[t-16] + s0(w[t-15]) (from round 16 on; before that the loaded word)
        // and h + K[t] are set aside so that the finishing cycle carries a shorter adder chain.
        if (state_reg == S_RD1)
        begin
            early_reg   <= (round_reg[5:4] == 2'b00);
            waddr_reg   <= round_reg[ADDR_W-1:0];
            hk_reg      <= work_reg[7] + sha_pkg::ROUND_K[round_reg];
            partial_reg <= (round_reg[5:4] == 2'b00)
                         ? ram_rdata_a
                         : ram_rdata_a + sha_pkg::small_sigma0(ram_rdata_b);
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    // Each stimulus row holds one message beat. Some rows also carry a digest
    // that is typed in by hand; the other rows are checked against the hash
    // predictor below.
    typedef struct packed {
        sha_pkg::in_beat_t beat;
        logic              typed;
        logic [255:0]      digest;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 16;
    localparam int RANDOM_ITEMS  = 314;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 400;
    localparam int TIMEOUT_NS    = 10_000_000;

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LENGTH_SLOT = 6'd56;

    // Known digests of the empty message and of "abc".
    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    localparam logic [255:0] START_H =
        256'h6a09e667_bb67ae85_3c6ef372_a54ff53a_510e527f_9b05688c_1f83d9ab_5be0cd19;

    localparam logic [64*32-1:0] ROUND_CONST = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic clk;
    logic rst_n;

    sha_stream_if #(.payload_t(sha_pkg::in_beat_t))  msg_ch ();
    sha_stream_if #(.payload_t(sha_pkg::out_beat_t)) digest_ch ();

    sha256_byte_stream_hasher_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (digest_ch)
    );

    // The directed part: an idle beat, the empty message, "abc" ended on its
    // last byte and again ended by a separate end beat, single-byte messages
    // at both byte extremes, an empty message right after a finished one to
    // show that the hasher really starts over, and a short mixed message.
    // Most invalid beats carry nonzero data to show that the byte is ignored.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{8'hff, 1'b0, 1'b0}, 1'b0, 256'h0},
        '{'{8'hff, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},
        '{'{8'h61, 1'b1, 1'b0}, 1'b0, 256'h0},
        '{'{8'h5a, 1'b0, 1'b0}, 1'b0, 256'h0},
        '{'{8'h62, 1'b1, 1'b0}, 1'b0, 256'h0},
        '{'{8'h63, 1'b1, 1'b1}, 1'b1, ABC_DIGEST},
        '{'{8'h61, 1'b1, 1'b0}, 1'b0, 256'h0},
        '{'{8'h62, 1'b1, 1'b0}, 1'b0, 256'h0},
        '{'{8'h63, 1'b1, 1'b0}, 1'b0, 256'h0},
        '{'{8'ha5, 1'b0, 1'b1}, 1'b1, ABC_DIGEST},
        '{'{8'h00, 1'b1, 1'b1}, 1'b0, 256'h0},
        '{'{8'hff, 1'b1, 1'b1}, 1'b0, 256'h0},
        '{'{8'h00, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},
        '{'{8'hff, 1'b1, 1'b0}, 1'b0, 256'h0},
        '{'{8'h00, 1'b1, 1'b0}, 1'b0, 256'h0},
        '{'{8'h80, 1'b1, 1'b1}, 1'b0, 256'h0}
    };

    // Every beat that will be offered, in order. It is filled at time zero
    // and then only read, by the driver and by the acceptance monitor.
    stim_row_t stim_q [$];

    // Digest words still owed by the hasher, oldest first.
    sha_pkg::out_beat_t digest_q [$];

    // Predictor state: the running hash of the message in progress.
    logic [31:0] chain_h [8];
    logic [63:0] bit_len;
    logic [7:0]  blk [64];
    logic [5:0]  fill;

    int send_idx;
    int acc_idx;
    int burst_left;
    int gap_left;
    int msg_count;
    int byte_count;
    int words_checked;
    int fail_count;

    logic [15:0] stall_pattern;
    logic [3:0]  stall_phase;

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Hash predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] twice;
        twice = {x, x};
        return twice[n +: 32];
    endfunction

    function automatic logic [31:0] lo_sig0(input logic [31:0] x);
        return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] lo_sig1(input logic [31:0] x);
        return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] up_sig0(input logic [31:0] x);
        return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic logic [31:0] up_sig1(input logic [31:0] x);
        return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
        begin
            chain_h[i] = START_H[255 - 32 * i -: 32];
        end
        bit_len = '0;
        fill    = '0;
    endtask

    // One full block through the 64 rounds, folded into the chain. The whole
    // message schedule is expanded up front here, unlike the rolling window
    // of sixteen words that the hardware keeps.
    task automatic fold_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int t = 0; t < 16; t++)
        begin
            w[t] = {blk[4 * t], blk[4 * t + 1], blk[4 * t + 2], blk[4 * t + 3]};
        end
        for (int t = 16; t < 64; t++)
        begin
            w[t] = lo_sig1(w[t - 2]) + w[t - 7] + lo_sig0(w[t - 15]) + w[t - 16];
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = chain_h[i];
        end
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + up_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
               + ROUND_CONST[2047 - 32 * t -: 32] + w[t];
            t2 = up_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--)
            begin
                v[j] = v[j - 1];
            end
            // After the shift v[4] holds the old d.
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            chain_h[i] = chain_h[i] + v[i];
        end
    endtask

    task automatic push_octet(input logic [7:0] b);
        blk[fill] = b;
        fill = fill + 6'd1;
        if (fill == 6'd0)
        begin
            fold_block();
        end
    endtask

    // Takes one accepted message beat. On an end beat it pads, finishes the
    // hash, hands back the digest and starts over for the next message.
    task automatic absorb_beat(input sha_pkg::in_beat_t b, output logic finished,
                               output logic [255:0] digest_val);
        logic [63:0] len;
        digest_val = '0;
        if (b.byte_valid)
        begin
            bit_len = bit_len + 64'd8;
            push_octet(b.data_byte);
        end
        finished = b.end_of_message;
        if (b.end_of_message)
        begin
            len = bit_len;
            push_octet(PAD_BYTE);
            while (fill != LENGTH_SLOT)
            begin
                push_octet(8'h00);
            end
            for (int i = 0; i < 8; i++)
            begin
                push_octet(len[63 - 8 * i -: 8]);
            end
            for (int i = 0; i < 8; i++)
            begin
                digest_val[255 - 32 * i -: 32] = chain_h[i];
            end
            restart_hash();
        end
    endtask

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    task automatic add_beat(input logic [7:0] data, input logic valid, input logic eom);
        stim_row_t row;
        row.beat.data_byte      = data;
        row.beat.byte_valid     = valid;
        row.beat.end_of_message = eom;
        row.typed               = 1'b0;
        row.digest              = '0;
        stim_q.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Message sender: bursts of random length with random gaps between
    // them. Between beats of a burst valid stays high, so a new beat is
    // loaded in the same edge that takes the previous one. Long bursts with
    // no gap at all show up now and then.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_ch.valid   <= 1'b0;
            msg_ch.payload <= '0;
            send_idx   = 0;
            burst_left = 1;
            gap_left   = 0;
        end
        else if (!msg_ch.valid || msg_ch.ready)
        begin
            if (gap_left != 0)
            begin
                gap_left = gap_left - 1;
                msg_ch.valid <= 1'b0;
            end
            else if (send_idx < stim_q.size())
            begin
                msg_ch.payload <= stim_q[send_idx].beat;
                msg_ch.valid   <= 1'b1;
                send_idx++;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                msg_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Digest receiver: ready follows a sixteen-bit pattern that is redrawn
    // at the end of every pass. Some patterns are all ones, some dense, some
    // sparse; bit zero is always set, so no stall lasts longer than a pass.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digest_ch.ready <= 1'b0;
            stall_phase     <= '0;
            stall_pattern   <= 16'hffff;
        end
        else
        begin
            digest_ch.ready <= stall_pattern[stall_phase];
            stall_phase     <= stall_phase + 4'd1;
            if (stall_phase == 4'd15)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern <= 16'hffff;
                    1:       stall_pattern <= 16'($urandom) | 16'h0001;
                    2:       stall_pattern <= 16'($urandom & $urandom & $urandom) | 16'h0001;
                    default: stall_pattern <= 16'($urandom | $urandom) | 16'h0001;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Acceptance monitor and digest checker. Both look at the values that
    // stood before the edge, so they do not care in which order the block
    // and the bench update at that edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        logic               finished;
        logic [255:0]       digest_val;
        sha_pkg::out_beat_t word;
        sha_pkg::out_beat_t got;
        sha_pkg::out_beat_t want;
        if (rst_n && msg_ch.valid && msg_ch.ready)
        begin
            absorb_beat(msg_ch.payload, finished, digest_val);
            if (msg_ch.payload.byte_valid)
            begin
                byte_count++;
            end
            if (finished)
            begin
                // Rows with a hand-typed digest take it in place of the
                // predicted one.
                if (stim_q[acc_idx].typed)
                begin
                    digest_val = stim_q[acc_idx].digest;
                end
                for (int i = 0; i < 8; i++)
                begin
                    word.digest_word = digest_val[255 - 32 * i -: 32];
                    word.word_index  = i[2:0];
                    word.last_word   = (i == 7);
                    digest_q.push_back(word);
                end
                msg_count++;
            end
            acc_idx++;
        end
        if (rst_n && digest_ch.valid && digest_ch.ready)
        begin
            got = digest_ch.payload;
            if (digest_q.size() == 0)
            begin
                note_failure($sformatf("digest beat with nothing owed: word %h idx %0d last %b",
                                       got.digest_word, got.word_index, got.last_word));
            end
            else
            begin
                want = digest_q.pop_front();
                if (got.digest_word !== want.digest_word ||
                    got.word_index !== want.word_index ||
                    got.last_word !== want.last_word)
                begin
                    note_failure($sformatf("want word %h idx %0d last %b, got %h idx %0d last %b",
                                           want.digest_word, want.word_index, want.last_word,
                                           got.digest_word, got.word_index, got.last_word));
                end
                words_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: build the stimulus, reset, let it run, drain, report.
    // ------------------------------------------------------------------
    initial
    begin : main
        int random_items;
        int msg_n;
        int len;
        int boundary_len [4];
        logic end_alone;
        logic eom;
        int k;

        clk             = 1'b0;
        rst_n           = 1'b0;
        msg_ch.valid    = 1'b0;
        msg_ch.payload  = '0;
        digest_ch.ready = 1'b0;
        acc_idx         = 0;
        msg_count       = 0;
        byte_count      = 0;
        words_checked   = 0;
        fail_count      = 0;
        restart_hash();

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            stim_q.push_back(directed_rows[i]);
        end

        // Random messages. The first four sit on the padding boundaries:
        // 55 bytes still leave room for the length in the same block, 56 push
        // it into an extra block, 63 and 64 fill the block right up. After
        // that most messages are short, with an occasional one of 50 to 130
        // bytes. Idle beats with random data are sprinkled in as noise, and
        // a message is ended either on its last byte or by an end beat of
        // its own.
        boundary_len = '{55, 56, 63, 64};
        random_items = 0;
        msg_n        = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (msg_n < 4)
            begin
                len = boundary_len[msg_n];
            end
            else if ($urandom_range(0, 11) == 0)
            begin
                len = $urandom_range(50, 130);
            end
            else
            begin
                len = $urandom_range(0, 12);
            end
            end_alone = (len == 0) || ($urandom_range(0, 1) == 1);
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    add_beat(8'($urandom), 1'b0, 1'b0);
                    random_items++;
                end
                eom = (k == len - 1) && !end_alone;
                add_beat(8'($urandom), 1'b1, eom);
                random_items++;
            end
            if (end_alone)
            begin
                add_beat(8'($urandom), 1'b0, 1'b1);
                random_items++;
            end
            msg_n++;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (acc_idx < stim_q.size())
        begin
            @(posedge clk);
        end

        k = 0;
        while (digest_q.size() != 0 && k < DRAIN_LIMIT)
        begin
            @(posedge clk);
            k++;
        end

        // Give the block time to show any stray digest beat.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (digest_q.size() != 0)
        begin
            note_failure($sformatf("%0d digest words never arrived", digest_q.size()));
        end

        $display("Hashed %0d messages (%0d message bytes in %0d beats) under random gaps",
                 msg_count, byte_count, stim_q.size());
        $display("and receiver stalls; %0d digest words checked, %0d failures.",
                 words_checked, fail_count);
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hard stop in case the hasher hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Run timed out after %0d ns.", TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
